[hdl/uer_pkg.sv]
`timescale 1ns / 1ps

package uer_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int STAMP_BITS_DEF = 16;

  localparam int PHASE_W   = 18;
  localparam int DELAY_W   = 16;
  localparam int WIDTH_W   = 10;
  localparam int WINDOW_W  = 16;
  localparam int TIMEOUT_W = 16;
  localparam int SCALE_W   = 12;
  localparam int LEVELS_W  = 4;
  localparam int DIST_W    = 20;
  localparam int PRODUCT_W = 28;
  localparam int DIST_LSB  = 8;
  localparam int TRIG_END_W = 17;
  localparam int PADDR_W   = 5;

  localparam logic [2:0] REG_PERIOD  = 3'd0;
  localparam logic [2:0] REG_DELAY   = 3'd1;
  localparam logic [2:0] REG_WIDTH   = 3'd2;
  localparam logic [2:0] REG_WINDOW  = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;
  localparam logic [2:0] REG_SCALE   = 3'd5;

  localparam logic [PHASE_W-1:0]   PERIOD_RST  = 18'd102010;
  localparam logic [DELAY_W-1:0]   DELAY_RST   = 16'd2000;
  localparam logic [WIDTH_W-1:0]   WIDTH_RST   = 10'd10;
  localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 16'd30000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd30000;
  localparam logic [SCALE_W-1:0]   SCALE_RST   = 12'd1124;

  typedef struct packed {
    logic [PHASE_W-1:0]   period;
    logic [DELAY_W-1:0]   delay;
    logic [WIDTH_W-1:0]   width;
    logic [WINDOW_W-1:0]  window;
    logic [TIMEOUT_W-1:0] timeout;
    logic [SCALE_W-1:0]   scale;
  } cfg_t;

  typedef struct packed {
    logic phase_zero;
    logic close_hit;
    logic trigger;
    logic window;
  } frame_status_t;

endpackage

[hdl/uer_apb_regs.sv]
`timescale 1ns / 1ps

module uer_apb_regs import uer_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period  <= PERIOD_RST;
      cfg_r.delay   <= DELAY_RST;
      cfg_r.width   <= WIDTH_RST;
      cfg_r.window  <= WINDOW_RST;
      cfg_r.timeout <= TIMEOUT_RST;
      cfg_r.scale   <= SCALE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PERIOD:  cfg_r.period  <= pwdata[PHASE_W-1:0];
        REG_DELAY:   cfg_r.delay   <= pwdata[DELAY_W-1:0];
        REG_WIDTH:   cfg_r.width   <= pwdata[WIDTH_W-1:0];
        REG_WINDOW:  cfg_r.window  <= pwdata[WINDOW_W-1:0];
        REG_TIMEOUT: cfg_r.timeout <= pwdata[TIMEOUT_W-1:0];
        REG_SCALE:   cfg_r.scale   <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PERIOD:  prdata = 32'(cfg_r.period);
      REG_DELAY:   prdata = 32'(cfg_r.delay);
      REG_WIDTH:   prdata = 32'(cfg_r.width);
      REG_WINDOW:  prdata = 32'(cfg_r.window);
      REG_TIMEOUT: prdata = 32'(cfg_r.timeout);
      REG_SCALE:   prdata = 32'(cfg_r.scale);
      default:     prdata = 32'd0;
    endcase
  end

endmodule

[hdl/uer_timing.sv]
`timescale 1ns / 1ps

module uer_timing import uer_pkg::*; #(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  cfg_t                  cfg,
  output frame_status_t         status,
  output logic [STAMP_BITS-1:0] stamp
);

  logic [PHASE_W-1:0]    phase_r;
  logic [PHASE_W-1:0]    phase_nxt;
  logic [STAMP_BITS-1:0] stamp_r;
  logic [TRIG_END_W-1:0] trig_end_r;
  logic [PHASE_W-1:0]    close_at_r;
  logic [PHASE_W:0]      phase_inc;

  // event points only move with config writes, which the user must make while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    trig_end_r <= TRIG_END_W'(cfg.delay) + TRIG_END_W'(cfg.width);
    close_at_r <= PHASE_W'(TRIG_END_W'(cfg.delay) + TRIG_END_W'(cfg.width))
                + PHASE_W'(cfg.window);
  end

  assign status.phase_zero = (phase_r == '0);
  assign status.close_hit  = (phase_r == close_at_r);
  assign status.window     = (phase_r < close_at_r);
  assign status.trigger    = (phase_r >= PHASE_W'(cfg.delay))
                          && (phase_r < PHASE_W'(trig_end_r));
  assign stamp = stamp_r;

  assign phase_inc = (PHASE_W+1)'(phase_r) + 1'b1;
  assign phase_nxt = (phase_inc >= (PHASE_W+1)'(cfg.period)) ? '0 : phase_inc[PHASE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      stamp_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      stamp_r <= stamp_r + 1'b1;
    end
  end

endmodule

[hdl/uer_channel.sv]
`timescale 1ns / 1ps

module uer_channel import uer_pkg::*; #(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  level,
  input  frame_status_t         status,
  input  logic [STAMP_BITS-1:0] stamp,
  input  logic [TIMEOUT_W-1:0]  timeout,
  input  logic [SCALE_W-1:0]    scale,
  output logic                  upd,
  output logic [DIST_W-1:0]     held_dist
);

  localparam int CMP_W = (STAMP_BITS > TIMEOUT_W) ? STAMP_BITS : TIMEOUT_W;
  localparam int MUL_W = (STAMP_BITS < TIMEOUT_W) ? STAMP_BITS : TIMEOUT_W;

  logic                  armed_r, armed_nxt;
  logic                  await_r, await_nxt;
  logic                  prior_r;
  logic [STAMP_BITS-1:0] rise_r, rise_nxt;
  logic [DIST_W-1:0]     dist_r, dist_nxt;

  logic                  armed_eff, await_eff;
  logic                  rise, fall, len_ok;
  logic [STAMP_BITS-1:0] diff;
  logic [PRODUCT_W-1:0]  prod;

  assign armed_eff = status.phase_zero ? 1'b1 : armed_r;
  assign await_eff = status.phase_zero ? 1'b0 : await_r;
  assign rise      = level && !prior_r;
  assign fall      = !level && prior_r;
  assign diff      = stamp - rise_r;
  assign len_ok    = (diff != '0) && (CMP_W'(diff) <= CMP_W'(timeout));
  // an accepted length never exceeds the timeout, so its low bits suffice
  assign prod      = PRODUCT_W'(diff[MUL_W-1:0]) * PRODUCT_W'(scale);

  always_comb begin
    armed_nxt = armed_eff;
    await_nxt = await_eff;
    rise_nxt  = rise_r;
    dist_nxt  = dist_r;
    upd       = 1'b0;
    if (armed_eff) begin
      if (!await_eff && rise) begin
        rise_nxt  = stamp;
        await_nxt = 1'b1;
      end else if (await_eff && fall) begin
        if (len_ok) begin
          dist_nxt = prod[DIST_LSB +: DIST_W];
          upd      = 1'b1;
        end
        armed_nxt = 1'b0;
        await_nxt = 1'b0;
      end
    end
    if (status.close_hit) begin
      armed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      await_r <= 1'b0;
      prior_r <= 1'b0;
      rise_r  <= '0;
      dist_r  <= '0;
    end else if (adv) begin
      armed_r <= armed_nxt;
      await_r <= await_nxt;
      prior_r <= level;
      rise_r  <= rise_nxt;
      dist_r  <= dist_nxt;
    end
  end

  // held distance only changes when a result is loaded, so it doubles as output
  assign held_dist = dist_r;

endmodule

[hdl/ultrasonic_echo_ranger_core.sv]
// Accepted data passes the input register, then the result register, to the result channel.
// Throughput: one tick per clock cycle while out_ready does not stall the result register;
// the input register and the result register overlap, with the channel logic between them.
// Reset (synchronous, rst_n low): phase, tick stamp and all channel state cleared,
// registers return to their defaults, both pipeline stages empty.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_core import uer_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LEVELS_W-1:0] in_echo_levels,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_trigger_level,
  output logic                out_window_open,
  output logic                out_frame_done,
  output logic [LEVELS_W-1:0] out_update_mask,
  output logic [DIST_W-1:0]   out_distance_ch0,
  output logic [DIST_W-1:0]   out_distance_ch1,
  output logic [DIST_W-1:0]   out_distance_ch2,
  output logic [DIST_W-1:0]   out_distance_ch3,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t                  cfg;
  frame_status_t         status;
  logic [STAMP_BITS-1:0] stamp;

  logic                  s1_valid_r;
  logic [LEVELS_W-1:0]   s1_levels_r;
  logic                  adv;

  logic                  out_valid_r;
  logic                  trigger_r, window_r, frame_r;
  logic [LEVELS_W-1:0]   mask_r, mask_nxt;

  logic [CHANNELS-1:0]   upd;
  logic [DIST_W-1:0]     chan_dist [CHANNELS];
  logic [DIST_W-1:0]     dist_out [LEVELS_W];

  uer_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage 1 moves into the result register when that register is free or being taken
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_levels_r <= in_echo_levels;
    end
  end

  uer_timing #(
    .STAMP_BITS (STAMP_BITS)
  ) u_timing (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .cfg    (cfg),
    .status (status),
    .stamp  (stamp)
  );

  for (genvar n = 0; n < CHANNELS; n++) begin : g_chan
    logic level;
    if (n < LEVELS_W) begin : g_pin
      assign level = s1_levels_r[n];
    end else begin : g_nopin
      assign level = 1'b0;
    end

    uer_channel #(
      .STAMP_BITS (STAMP_BITS)
    ) u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .level     (level),
      .status    (status),
      .stamp     (stamp),
      .timeout   (cfg.timeout),
      .scale     (cfg.scale),
      .upd       (upd[n]),
      .held_dist (chan_dist[n])
    );
  end

  for (genvar n = 0; n < LEVELS_W; n++) begin : g_report
    if (n < CHANNELS) begin : g_used
      assign mask_nxt[n] = upd[n];
      assign dist_out[n] = chan_dist[n];
    end else begin : g_unused
      assign mask_nxt[n] = 1'b0;
      assign dist_out[n] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trigger_r <= status.trigger;
      window_r  <= status.window;
      frame_r   <= status.close_hit;
      mask_r    <= mask_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_level = trigger_r;
  assign out_window_open   = window_r;
  assign out_frame_done    = frame_r;
  assign out_update_mask   = mask_r;
  assign out_distance_ch0  = dist_out[0];
  assign out_distance_ch1  = dist_out[1];
  assign out_distance_ch2  = dist_out[2];
  assign out_distance_ch3  = dist_out[3];

endmodule
